/* rtl/core/tatc_pkg.sv */
package tatc_pkg;

  // defaults for the top level parameters
  localparam int CHANNELS_DEF   = 3;
  localparam int ADC_FS_DEF     = 4095;
  localparam int MAX_WINDOW_DEF = 64;

  localparam int SMP_W     = 12;
  localparam int CH_W      = 2;
  localparam int TEMP_W    = 19;
  localparam int FAULT_W   = 2;
  localparam int OHMS_W    = 24;
  localparam int WIN_W     = 7;
  localparam int COEF_W    = 48;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C  = 3'd4;

  localparam logic [OHMS_W-1:0] DIVIDER_RST = 24'd100000;
  localparam logic [WIN_W-1:0]  WINDOW_RST  = 7'd10;
  localparam logic [COEF_W-1:0] COEF_A_RST  = 48'd244204200000;
  localparam logic [COEF_W-1:0] COEF_B_RST  = 48'd56088600000;
  localparam logic [COEF_W-1:0] COEF_C_RST  = 48'd37242100;

  localparam logic [FAULT_W-1:0] FAULT_OK   = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_FULL = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_ZERO = 2'd2;

  localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -19'sd69927;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 19'sd262143;

  // 70000*64 - kelvin offset in q.14 + rounding half
  localparam logic [63:0] KELVIN_OFS = 64'd4742;
  localparam logic signed [63:0] TEMP_BIAS = 64'sd70000;

  localparam int FRAC = 40;
  localparam int STEPS = 64;

  // decimal digits split in two halves, converted to q.40
  function automatic logic [63:0] q40(input logic [63:0] hi, input logic [63:0] lo);
    return ((hi << 32) / 64'd390625) + ((lo << 24) / 64'd152587890625);
  endfunction

  localparam logic [63:0] LN2_Q40 = q40(64'd69314718, 64'd5599453);

  localparam logic [63:0] LNTAB [8] = '{
    64'd0,
    q40(64'd11778303, 64'd56563835),
    q40(64'd22314355, 64'd13142098),
    q40(64'd31845373, 64'd11185346),
    q40(64'd40546510, 64'd81081644),
    q40(64'd48550781, 64'd57817008),
    q40(64'd55961578, 64'd79354227),
    q40(64'd62860865, 64'd94223741)
  };

  function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  typedef enum logic [4:0] {
    OP_NOP,
    OP_ACCUM,
    OP_CHECK,
    OP_NORM,
    OP_DIV_R,
    OP_TAKE_T,
    OP_MUL,
    OP_TAKE_POW,
    OP_ADD_Q,
    OP_LN_FIN,
    OP_TAKE_L,
    OP_TAKE_VAR,
    OP_ADD_VAR,
    OP_POS,
    OP_TEMP,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    MS_PW_T,
    MS_MAG_MAG,
    MS_L_MAG,
    MS_C_L,
    MS_B_MAG
  } msel_t;

  typedef struct packed {
    dp_op_t     op;
    msel_t      msel;
    logic [2:0] pow;
    logic       ln_den;
  } dp_cmd_t;

  typedef struct packed {
    logic ch_ok;
    logic emit;
    logic fault_hit;
    logic norm_done;
    logic mul_busy;
    logic div_busy;
    logic pos_le;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_NORM,
    ST_DIVR_W,
    ST_PMUL,
    ST_PMUL_W,
    ST_PDIV_W,
    ST_LNFIN,
    ST_MUL,
    ST_MUL_W,
    ST_POS,
    ST_DIVD_W,
    ST_DONE
  } state_t;

endpackage

/* rtl/core/tatc_ctrl.sv */
module tatc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  tatc_pkg::dp_stat_t stat,
  output tatc_pkg::dp_cmd_t  cmd
);

  tatc_pkg::state_t state_r, state_nxt;
  logic [2:0] pk_r, pk_nxt;
  logic [1:0] mstep_r, mstep_nxt;
  logic       den_r, den_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tatc_pkg::ST_IDLE;
      pk_r        <= 3'd2;
      mstep_r     <= 2'd0;
      den_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pk_r        <= pk_nxt;
      mstep_r     <= mstep_nxt;
      den_r       <= den_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    pk_nxt        = pk_r;
    mstep_nxt     = mstep_r;
    den_nxt       = den_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    in_tready     = 1'b0;
    cmd.op        = tatc_pkg::OP_NOP;
    cmd.msel      = tatc_pkg::MS_PW_T;
    cmd.pow       = pk_r;
    cmd.ln_den    = den_r;
    unique case (state_r)
      tatc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = tatc_pkg::OP_ACCUM;
          if (stat.ch_ok && stat.emit) state_nxt = tatc_pkg::ST_CHECK;
        end
      end
      tatc_pkg::ST_CHECK: begin
        cmd.op  = tatc_pkg::OP_CHECK;
        den_nxt = 1'b0;
        state_nxt = stat.fault_hit ? tatc_pkg::ST_DONE : tatc_pkg::ST_NORM;
      end
      tatc_pkg::ST_NORM: begin
        if (stat.norm_done) begin
          cmd.op    = tatc_pkg::OP_DIV_R;
          state_nxt = tatc_pkg::ST_DIVR_W;
        end else begin
          cmd.op = tatc_pkg::OP_NORM;
        end
      end
      tatc_pkg::ST_DIVR_W: begin
        if (!stat.div_busy) begin
          cmd.op    = tatc_pkg::OP_TAKE_T;
          pk_nxt    = 3'd2;
          state_nxt = tatc_pkg::ST_PMUL;
        end
      end
      tatc_pkg::ST_PMUL: begin
        cmd.op    = tatc_pkg::OP_MUL;
        cmd.msel  = tatc_pkg::MS_PW_T;
        state_nxt = tatc_pkg::ST_PMUL_W;
      end
      tatc_pkg::ST_PMUL_W: begin
        if (!stat.mul_busy) begin
          cmd.op = tatc_pkg::OP_TAKE_POW;
          // odd powers take a reciprocal multiply, even ones are shifts
          if (pk_r[0]) begin
            state_nxt = tatc_pkg::ST_PDIV_W;
          end else begin
            pk_nxt    = pk_r + 3'd1;
            state_nxt = tatc_pkg::ST_PMUL;
          end
        end
      end
      tatc_pkg::ST_PDIV_W: begin
        if (!stat.mul_busy) begin
          cmd.op = tatc_pkg::OP_ADD_Q;
          if (pk_r == 3'd5) begin
            state_nxt = tatc_pkg::ST_LNFIN;
          end else begin
            pk_nxt    = pk_r + 3'd1;
            state_nxt = tatc_pkg::ST_PMUL;
          end
        end
      end
      tatc_pkg::ST_LNFIN: begin
        cmd.op = tatc_pkg::OP_LN_FIN;
        if (!den_r) begin
          den_nxt   = 1'b1;
          state_nxt = tatc_pkg::ST_NORM;
        end else begin
          mstep_nxt = 2'd0;
          state_nxt = tatc_pkg::ST_MUL;
        end
      end
      tatc_pkg::ST_MUL: begin
        cmd.op = tatc_pkg::OP_MUL;
        case (mstep_r)
          2'd0:    cmd.msel = tatc_pkg::MS_MAG_MAG;
          2'd1:    cmd.msel = tatc_pkg::MS_L_MAG;
          2'd2:    cmd.msel = tatc_pkg::MS_C_L;
          default: cmd.msel = tatc_pkg::MS_B_MAG;
        endcase
        state_nxt = tatc_pkg::ST_MUL_W;
      end
      tatc_pkg::ST_MUL_W: begin
        if (!stat.mul_busy) begin
          case (mstep_r)
            2'd0, 2'd1: cmd.op = tatc_pkg::OP_TAKE_L;
            2'd2:       cmd.op = tatc_pkg::OP_TAKE_VAR;
            default:    cmd.op = tatc_pkg::OP_ADD_VAR;
          endcase
          if (mstep_r == 2'd3) begin
            state_nxt = tatc_pkg::ST_POS;
          end else begin
            mstep_nxt = mstep_r + 2'd1;
            state_nxt = tatc_pkg::ST_MUL;
          end
        end
      end
      tatc_pkg::ST_POS: begin
        cmd.op    = tatc_pkg::OP_POS;
        state_nxt = stat.pos_le ? tatc_pkg::ST_DONE : tatc_pkg::ST_DIVD_W;
      end
      tatc_pkg::ST_DIVD_W: begin
        if (!stat.div_busy) begin
          cmd.op    = tatc_pkg::OP_TEMP;
          state_nxt = tatc_pkg::ST_DONE;
        end
      end
      tatc_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = tatc_pkg::OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = tatc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tatc_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/tatc_dp.sv */
module tatc_dp #(
  parameter int CHANNELS       = tatc_pkg::CHANNELS_DEF,
  parameter int ADC_FULL_SCALE = tatc_pkg::ADC_FS_DEF,
  parameter int MAX_WINDOW     = tatc_pkg::MAX_WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tatc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tatc_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic [tatc_pkg::CH_W-1:0]            in_channel,
  input  logic [tatc_pkg::SMP_W-1:0]           in_sample,
  input  tatc_pkg::dp_cmd_t                    cmd,
  output tatc_pkg::dp_stat_t                   stat,
  output logic [tatc_pkg::CH_W-1:0]            out_channel,
  output logic signed [tatc_pkg::TEMP_W-1:0]   out_temperature,
  output logic [tatc_pkg::FAULT_W-1:0]         out_fault
);

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int W_W      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W    = $clog2(MAX_WINDOW * ADC_FULL_SCALE + 1);
  localparam int NUM_W    = SUM_W + tatc_pkg::OHMS_W;
  localparam int FRAC     = tatc_pkg::FRAC;

  // reciprocals for exact floor division by 3 (>> 65) and by 5 (>> 66)
  localparam logic [63:0] DIV3_MAGIC = 64'hAAAA_AAAA_AAAA_AAAB;
  localparam logic [63:0] DIV5_MAGIC = 64'hCCCC_CCCC_CCCC_CCCD;

  // configuration registers
  logic [tatc_pkg::OHMS_W-1:0] divider_r;
  logic [tatc_pkg::WIN_W-1:0]  window_r;
  logic [tatc_pkg::COEF_W-1:0] coef_a_r, coef_b_r, coef_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divider_r <= tatc_pkg::DIVIDER_RST;
      window_r  <= tatc_pkg::WINDOW_RST;
      coef_a_r  <= tatc_pkg::COEF_A_RST;
      coef_b_r  <= tatc_pkg::COEF_B_RST;
      coef_c_r  <= tatc_pkg::COEF_C_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tatc_pkg::REG_DIVIDER: divider_r <= cfg_wdata[tatc_pkg::OHMS_W-1:0];
        tatc_pkg::REG_WINDOW:  window_r  <= cfg_wdata[tatc_pkg::WIN_W-1:0];
        tatc_pkg::REG_COEF_A:  coef_a_r  <= cfg_wdata[tatc_pkg::COEF_W-1:0];
        tatc_pkg::REG_COEF_B:  coef_b_r  <= cfg_wdata[tatc_pkg::COEF_W-1:0];
        tatc_pkg::REG_COEF_C:  coef_c_r  <= cfg_wdata[tatc_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // per channel accumulation
  logic [SUM_W-1:0]          sums_r [CHANNELS];
  logic [W_W-1:0]            cnts_r [CHANNELS];
  logic [CH_IDX_W-1:0]       idx;
  logic [W_W-1:0]            w_eff;
  logic [tatc_pkg::SMP_W-1:0] s_clamp;
  logic [W_W-1:0]            cnt_inc;
  logic [SUM_W-1:0]          sum_add;

  assign idx = CH_IDX_W'(in_channel);

  always_comb begin
    if (window_r == '0) w_eff = W_W'(1);
    else if (int'(window_r) > MAX_WINDOW) w_eff = W_W'(MAX_WINDOW);
    else w_eff = W_W'(window_r);
    if (int'(in_sample) > ADC_FULL_SCALE) s_clamp = tatc_pkg::SMP_W'(ADC_FULL_SCALE);
    else s_clamp = in_sample;
  end

  assign cnt_inc = cnts_r[idx] + W_W'(1);
  assign sum_add = sums_r[idx] + SUM_W'(s_clamp);

  // working registers
  logic [tatc_pkg::CH_W-1:0]          ch_r;
  logic [SUM_W-1:0]                   sum_r, full_r;
  logic [tatc_pkg::FAULT_W-1:0]       fault_r;
  logic signed [tatc_pkg::TEMP_W-1:0] temp_r;
  logic [63:0] x_r;
  logic [6:0]  e_r;
  logic [63:0] t_r, pw_r, acc_r, lnn_r, mag_r, l_r, var_r;
  logic        neg_r;

  // shift-add multiplier, one bit a cycle
  logic [127:0] mp_r;
  logic [63:0]  mx_r;
  logic [6:0]   mcnt_r;
  logic         mstart;
  logic [63:0]  mxa, mya, mul_res;
  logic [64:0]  msum;

  assign msum    = {1'b0, mp_r[127:64]} + {1'b0, (mp_r[0] ? mx_r : 64'd0)};
  assign mul_res = (mp_r[127:FRAC+64] != '0) ? {64{1'b1}} : mp_r[FRAC+63:FRAC];

  // restoring divider, one quotient bit a cycle
  logic [63:0] dq_r, drem_r, dv_r;
  logic [6:0]  dcnt_r;
  logic        dstart;
  logic [63:0] dna, dda;
  logic [64:0] dtrial;

  assign dtrial = {drem_r, dq_r[63]} - {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r <= '0;
      dcnt_r <= '0;
    end else begin
      if (mstart) mcnt_r <= 7'(tatc_pkg::STEPS);
      else if (mcnt_r != '0) mcnt_r <= mcnt_r - 7'd1;
      if (dstart) dcnt_r <= 7'(tatc_pkg::STEPS);
      else if (dcnt_r != '0) dcnt_r <= dcnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (mstart) begin
      mp_r <= {64'd0, mya};
      mx_r <= mxa;
    end else if (mcnt_r != '0) begin
      mp_r <= {msum, mp_r[63:1]};
    end
    if (dstart) begin
      dq_r   <= dna;
      drem_r <= '0;
      dv_r   <= dda;
    end else if (dcnt_r != '0) begin
      if (!dtrial[64]) begin
        drem_r <= dtrial[63:0];
        dq_r   <= {dq_r[62:0], 1'b1};
      end else begin
        drem_r <= {drem_r[62:0], dq_r[63]};
        dq_r   <= {dq_r[62:0], 1'b0};
      end
    end
  end

  // combinational helpers
  logic [NUM_W-1:0]            num_w;
  logic [tatc_pkg::FAULT_W-1:0] fault_w;
  logic [2:0]   k;
  logic [47:0]  eln;
  logic [63:0]  ln_val;
  logic [63:0]  pos, negp, posd;
  logic [63:0]  xk;
  logic signed [63:0] tt;
  logic [63:0]  quo;

  assign num_w = NUM_W'(sum_r) * NUM_W'(divider_r);
  assign k     = x_r[39:37];
  assign eln   = 48'(e_r) * 48'(tatc_pkg::LN2_Q40);
  assign ln_val = 64'(eln) + tatc_pkg::LNTAB[k] + acc_r;
  assign pos   = neg_r ? 64'(coef_a_r) : tatc_pkg::sat_add(64'(coef_a_r), var_r);
  assign negp  = neg_r ? var_r : 64'd0;
  assign posd  = pos - negp;
  assign xk    = dq_r + tatc_pkg::KELVIN_OFS;
  assign tt    = $signed({6'd0, xk[63:6]}) - tatc_pkg::TEMP_BIAS;
  assign quo   = (cmd.pow == 3'd3) ? {1'b0, mp_r[127:65]} : {2'd0, mp_r[127:66]};

  always_comb begin
    if (sum_r >= full_r) fault_w = tatc_pkg::FAULT_FULL;
    else if (sum_r == '0 || divider_r == '0) fault_w = tatc_pkg::FAULT_ZERO;
    else fault_w = tatc_pkg::FAULT_OK;
  end

  always_comb begin
    stat.ch_ok     = int'(in_channel) < CHANNELS;
    stat.emit      = cnt_inc >= w_eff;
    stat.fault_hit = fault_w != tatc_pkg::FAULT_OK;
    stat.norm_done = (x_r[63:41] == '0) && x_r[40];
    stat.mul_busy  = mcnt_r != '0;
    stat.div_busy  = dcnt_r != '0;
    stat.pos_le    = pos <= negp;
  end

  // unit start decode
  always_comb begin
    mstart = 1'b0;
    mxa    = pw_r;
    mya    = t_r;
    dstart = 1'b0;
    dna    = {24'd0, x_r[36:0], 3'd0};
    dda    = 64'(4'd8 + {1'b0, k});
    unique case (cmd.op)
      tatc_pkg::OP_MUL: begin
        mstart = 1'b1;
        case (cmd.msel)
          tatc_pkg::MS_MAG_MAG: begin mxa = mag_r;            mya = mag_r; end
          tatc_pkg::MS_L_MAG:   begin mxa = l_r;              mya = mag_r; end
          tatc_pkg::MS_C_L:     begin mxa = 64'(coef_c_r);    mya = l_r;   end
          tatc_pkg::MS_B_MAG:   begin mxa = 64'(coef_b_r);    mya = mag_r; end
          default:              begin mxa = pw_r;             mya = t_r;   end
        endcase
      end
      tatc_pkg::OP_DIV_R: dstart = 1'b1;
      tatc_pkg::OP_TAKE_POW: begin
        if (cmd.pow[0]) begin
          mstart = 1'b1;
          mxa    = mul_res;
          mya    = (cmd.pow == 3'd3) ? DIV3_MAGIC : DIV5_MAGIC;
        end
      end
      tatc_pkg::OP_POS: begin
        if (!(pos <= negp)) begin
          dstart = 1'b1;
          dna    = 64'd1 << 62;
          dda    = posd;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sums_r[i] <= '0;
        cnts_r[i] <= '0;
      end
    end else if (cmd.op == tatc_pkg::OP_ACCUM && stat.ch_ok) begin
      if (stat.emit) begin
        sums_r[idx] <= '0;
        cnts_r[idx] <= '0;
      end else begin
        sums_r[idx] <= sum_add;
        cnts_r[idx] <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      tatc_pkg::OP_ACCUM: begin
        ch_r   <= in_channel;
        sum_r  <= sum_add;
        full_r <= SUM_W'(w_eff * ADC_FULL_SCALE);
      end
      tatc_pkg::OP_CHECK: begin
        fault_r <= fault_w;
        temp_r  <= (fault_w == tatc_pkg::FAULT_FULL) ? tatc_pkg::TEMP_LOW : tatc_pkg::TEMP_HIGH;
        x_r     <= 64'(num_w);
        e_r     <= 7'(FRAC);
      end
      tatc_pkg::OP_NORM: begin
        if (x_r[63:41] != '0) begin
          x_r <= x_r >> 1;
          e_r <= e_r + 7'd1;
        end else begin
          x_r <= x_r << 1;
          e_r <= e_r - 7'd1;
        end
      end
      tatc_pkg::OP_TAKE_T: begin
        t_r   <= dq_r;
        pw_r  <= dq_r;
        acc_r <= dq_r;
      end
      tatc_pkg::OP_TAKE_POW: begin
        pw_r <= mul_res;
        if (cmd.pow == 3'd2) acc_r <= acc_r - (mul_res >> 1);
        else if (cmd.pow == 3'd4) acc_r <= acc_r - (mul_res >> 2);
      end
      tatc_pkg::OP_ADD_Q: acc_r <= acc_r + quo;
      tatc_pkg::OP_LN_FIN: begin
        if (!cmd.ln_den) begin
          lnn_r <= ln_val;
          // denominator of the divider goes next
          x_r   <= 64'(full_r - sum_r);
          e_r   <= 7'(FRAC);
        end else begin
          neg_r <= lnn_r < ln_val;
          mag_r <= (lnn_r < ln_val) ? (ln_val - lnn_r) : (lnn_r - ln_val);
        end
      end
      tatc_pkg::OP_TAKE_L:   l_r   <= mul_res;
      tatc_pkg::OP_TAKE_VAR: var_r <= mul_res;
      tatc_pkg::OP_ADD_VAR:  var_r <= tatc_pkg::sat_add(var_r, mul_res);
      tatc_pkg::OP_POS: begin
        if (pos <= negp) temp_r <= tatc_pkg::TEMP_HIGH;
      end
      tatc_pkg::OP_TEMP: begin
        if (tt > 64'(tatc_pkg::TEMP_HIGH)) temp_r <= tatc_pkg::TEMP_HIGH;
        else if (tt < 64'(tatc_pkg::TEMP_LOW)) temp_r <= tatc_pkg::TEMP_LOW;
        else temp_r <= tt[tatc_pkg::TEMP_W-1:0];
      end
      tatc_pkg::OP_EMIT: begin
        out_channel     <= ch_r;
        out_temperature <= temp_r;
        out_fault       <= fault_r;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/thermistor_average_to_celsius.sv */
// Sums 12-bit converter samples per channel and, once a channel has collected
// window_len samples, converts the average divider reading into a temperature
// with the Steinhart-Hart equation, reported in signed 1/256 degree C together
// with the channel and a fault code (full scale or zero reading). A sample that
// does not complete a window is accumulated while the block stays ready. A sample
// that completes a window holds off the next one until its result is in the
// output register, computed with one shared 64-step shift-add multiplier and
// one shared 64-step restoring divider, used for two logarithms (each one
// normalize loop of up to 40 shifts, one division and six multiplications, two
// of them reciprocal multiplies that divide by 3 and 5) and then four
// multiplications and the final reciprocal; a faulty window skips all of this.
// A finished result waits in the output register while new samples are accepted.
module thermistor_average_to_celsius #(
  parameter int CHANNELS       = tatc_pkg::CHANNELS_DEF,
  parameter int ADC_FULL_SCALE = tatc_pkg::ADC_FS_DEF,
  parameter int MAX_WINDOW     = tatc_pkg::MAX_WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tatc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tatc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // adc_sample[11:0], zero pad
  input  logic [1:0]                     in_tuser,   // channel[1:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // temperature[18:0], zero pad
  output logic [3:0]                     out_tuser   // out_channel[1:0], fault[3:2]
);

  tatc_pkg::dp_cmd_t  cmd;
  tatc_pkg::dp_stat_t stat;
  logic [tatc_pkg::CH_W-1:0]          o_ch;
  logic signed [tatc_pkg::TEMP_W-1:0] o_temp;
  logic [tatc_pkg::FAULT_W-1:0]       o_fault;

  tatc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tatc_dp #(
    .CHANNELS       (CHANNELS),
    .ADC_FULL_SCALE (ADC_FULL_SCALE),
    .MAX_WINDOW     (MAX_WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_channel      (in_tuser),
    .in_sample       (in_tdata[tatc_pkg::SMP_W-1:0]),
    .cmd             (cmd),
    .stat            (stat),
    .out_channel     (o_ch),
    .out_temperature (o_temp),
    .out_fault       (o_fault)
  );

  assign out_tdata = {5'd0, o_temp};
  assign out_tuser = {o_fault, o_ch};

endmodule

/* tb/thermistor_average_to_celsius_test.sv */
`timescale 1ns / 100ps

module thermistor_average_to_celsius_test;

  localparam int NCH = 3;
  localparam int FS = 4095;
  localparam int MAXW = 64;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int LONG_HOLD = 6000;
  localparam logic [63:0] LN2_Q = (64'd69314718 << 32) / 64'd390625
                                  + (64'd5599453 << 24) / 64'd152587890625;

  typedef struct {
    logic [tatc_pkg::CH_W-1:0] ch;
    logic signed [tatc_pkg::TEMP_W-1:0] temp;
    logic [tatc_pkg::FAULT_W-1:0] fault;
  } reading_t;

  typedef struct {
    logic [1:0] ch;
    logic [11:0] smp;
    bit typed;
    logic [tatc_pkg::FAULT_W-1:0] fault;
    logic signed [tatc_pkg::TEMP_W-1:0] temp;
  } sample_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [tatc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tatc_pkg::CFG_W-1:0] cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [15:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [23:0] out_tdata;
  logic [3:0] out_tuser;

  // shadow of the block's registers and per-channel accumulators
  logic [tatc_pkg::OHMS_W-1:0] m_ohms;
  logic [tatc_pkg::WIN_W-1:0] m_window;
  logic [63:0] m_coef_a, m_coef_b, m_coef_c;
  logic [31:0] m_sums [NCH];
  logic [31:0] m_counts [NCH];

  reading_t pending_temps [$];
  int errors = 0;
  bit tx_gaps = 1;
  bit rx_gaps = 1;
  bit long_hold_req = 0;
  int idle_cycles = 0;

  sample_row_t directed_rows [] = '{
    '{2'd0, 12'd0,    1, tatc_pkg::FAULT_ZERO, tatc_pkg::TEMP_HIGH},
    '{2'd1, 12'd4095, 1, tatc_pkg::FAULT_FULL, tatc_pkg::TEMP_LOW},
    '{2'd2, 12'd2048, 0, tatc_pkg::FAULT_OK, '0},
    '{2'd0, 12'd1,    0, tatc_pkg::FAULT_OK, '0},
    '{2'd1, 12'd4094, 0, tatc_pkg::FAULT_OK, '0},
    '{2'd3, 12'd1234, 0, tatc_pkg::FAULT_OK, '0},
    '{2'd3, 12'd4095, 0, tatc_pkg::FAULT_OK, '0},
    '{2'd2, 12'd100,  0, tatc_pkg::FAULT_OK, '0},
    '{2'd0, 12'd3000, 0, tatc_pkg::FAULT_OK, '0},
    '{2'd1, 12'd500,  0, tatc_pkg::FAULT_OK, '0},
    '{2'd2, 12'd4000, 0, tatc_pkg::FAULT_OK, '0},
    '{2'd0, 12'd2730, 0, tatc_pkg::FAULT_OK, '0},
    '{2'd1, 12'd1365, 0, tatc_pkg::FAULT_OK, '0},
    '{2'd2, 12'd0,    1, tatc_pkg::FAULT_ZERO, tatc_pkg::TEMP_HIGH},
    '{2'd0, 12'd4095, 1, tatc_pkg::FAULT_FULL, tatc_pkg::TEMP_LOW}
  };

  thermistor_average_to_celsius u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] mul_frac(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = x * y;
    return (p[127:104] != 0) ? {64{1'b1}} : p[103:40];
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic [63:0] log_frac(input logic [63:0] x);
    int e;
    logic [63:0] f, r, t, t2, t3, t4, t5, p, tab;
    logic [2:0] k;
    e = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    f = (e <= 40) ? (x << (40 - e)) : (x >> (e - 40));
    k = f[39:37];
    r = f - ((64'd8 + k) << 37);
    t = (r << 3) / (64'd8 + k);
    t2 = mul_frac(t, t);
    t3 = mul_frac(t2, t);
    t4 = mul_frac(t3, t);
    t5 = mul_frac(t4, t);
    p = t + t3 / 3 + t5 / 5 - t2 / 2 - t4 / 4;
    case (k)
      3'd0: tab = 64'd0;
      3'd1: tab = (64'd11778303 << 32) / 64'd390625 + (64'd56563835 << 24) / 64'd152587890625;
      3'd2: tab = (64'd22314355 << 32) / 64'd390625 + (64'd13142098 << 24) / 64'd152587890625;
      3'd3: tab = (64'd31845373 << 32) / 64'd390625 + (64'd11185346 << 24) / 64'd152587890625;
      3'd4: tab = (64'd40546510 << 32) / 64'd390625 + (64'd81081644 << 24) / 64'd152587890625;
      3'd5: tab = (64'd48550781 << 32) / 64'd390625 + (64'd57817008 << 24) / 64'd152587890625;
      3'd6: tab = (64'd55961578 << 32) / 64'd390625 + (64'd79354227 << 24) / 64'd152587890625;
      default: tab = (64'd62860865 << 32) / 64'd390625
                     + (64'd94223741 << 24) / 64'd152587890625;
    endcase
    return 64'(e) * LN2_Q + tab + p;
  endfunction

  function automatic logic signed [tatc_pkg::TEMP_W-1:0] steinhart(input logic [63:0] sum,
                                                                  input logic [63:0] full);
    logic [63:0] ln_n, ln_d, mag, l3, var_part, pos, negp, x;
    logic signed [63:0] t;
    bit neg;
    ln_n = log_frac(sum * m_ohms);
    ln_d = log_frac(full - sum);
    neg = ln_n < ln_d;
    mag = neg ? ln_d - ln_n : ln_n - ln_d;
    l3 = mul_frac(mul_frac(mag, mag), mag);
    var_part = add_sat(mul_frac(m_coef_b, mag), mul_frac(m_coef_c, l3));
    pos = neg ? m_coef_a : add_sat(m_coef_a, var_part);
    negp = neg ? var_part : 64'd0;
    if (pos <= negp) return tatc_pkg::TEMP_HIGH;
    x = (64'd1 << 62) / (pos - negp);
    x = x + 64'd4480000 - 64'd4475290 + 64'd32;
    t = $signed(x >> 6) - 64'sd70000;
    if (t > 64'sd262143) t = 64'sd262143;
    if (t < -64'sd69927) t = -64'sd69927;
    return t[tatc_pkg::TEMP_W-1:0];
  endfunction

  // accumulate one sample, return 1 when the channel's window completes
  function automatic bit average_sample(input logic [1:0] ch, input logic [11:0] smp,
                                        output reading_t rd);
    logic [31:0] s, w;
    logic [63:0] sum, full;
    s = (smp > FS) ? FS : smp;
    w = m_window;
    rd = '{ch, '0, tatc_pkg::FAULT_OK};
    if (ch >= NCH) return 0;
    if (w == 0) w = 1;
    if (w > MAXW) w = MAXW;
    m_sums[ch] += s;
    m_counts[ch] += 1;
    if (m_counts[ch] < w) return 0;
    sum = m_sums[ch];
    full = w * FS;
    m_sums[ch] = 0;
    m_counts[ch] = 0;
    if (sum >= full) begin
      rd.fault = tatc_pkg::FAULT_FULL;
      rd.temp = tatc_pkg::TEMP_LOW;
    end else if (sum == 0 || m_ohms == 0) begin
      rd.fault = tatc_pkg::FAULT_ZERO;
      rd.temp = tatc_pkg::TEMP_HIGH;
    end else begin
      rd.temp = steinhart(sum, full);
    end
    return 1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(input logic [tatc_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[tatc_pkg::CFG_W-1:0];
    case (idx)
      tatc_pkg::REG_DIVIDER: m_ohms = value[tatc_pkg::OHMS_W-1:0];
      tatc_pkg::REG_WINDOW:  m_window = value[tatc_pkg::WIN_W-1:0];
      tatc_pkg::REG_COEF_A:  m_coef_a = {16'd0, value[47:0]};
      tatc_pkg::REG_COEF_B:  m_coef_b = {16'd0, value[47:0]};
      tatc_pkg::REG_COEF_C:  m_coef_c = {16'd0, value[47:0]};
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_temps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_sample(input logic [1:0] ch, input logic [11:0] smp, input bit typed,
                             input logic [tatc_pkg::FAULT_W-1:0] tf,
                             input logic signed [tatc_pkg::TEMP_W-1:0] tt);
    reading_t rd;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= ch;
    in_tdata <= {4'd0, smp};
    do @(posedge clk); while (!in_tready);
    if (average_sample(ch, smp, rd)) begin
      if (typed) begin
        rd.fault = tf;
        rd.temp = tt;
      end
      pending_temps.push_back(rd);
    end
  endtask

  task automatic random_sample();
    logic [1:0] ch;
    logic [11:0] smp;
    ch = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 9))
      0: smp = 12'd0;
      1: smp = 12'd4095;
      2: smp = 12'($urandom_range(0, 15));
      3: smp = 12'($urandom_range(4080, 4095));
      default: smp = 12'($urandom);
    endcase
    send_sample(ch, smp, 0, tatc_pkg::FAULT_OK, '0);
  endtask

  // result side: random or long hold-offs, check every transaction
  initial begin
    out_tready <= 1'b0;
    forever begin
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 0;
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_temps.size() == 0) begin
        $display("unexpected result transaction at %0t", $realtime);
        errors++;
      end else begin
        want = pending_temps.pop_front();
        if (out_tuser[1:0] != want.ch) report_mismatch("channel", out_tuser[1:0], want.ch);
        if ($signed(out_tdata[18:0]) != want.temp)
          report_mismatch("temperature", $signed(out_tdata[18:0]), want.temp);
        if (out_tuser[3:2] != want.fault) report_mismatch("fault", out_tuser[3:2], want.fault);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    m_ohms = tatc_pkg::DIVIDER_RST;
    m_window = tatc_pkg::WINDOW_RST;
    m_coef_a = tatc_pkg::COEF_A_RST;
    m_coef_b = tatc_pkg::COEF_B_RST;
    m_coef_c = tatc_pkg::COEF_C_RST;
    for (int i = 0; i < NCH; i++) begin
      m_sums[i] = 0;
      m_counts[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-sample window so every directed row but the bad channel gives a result
    write_reg(tatc_pkg::REG_WINDOW, 64'd1);
    foreach (directed_rows[i])
      send_sample(directed_rows[i].ch, directed_rows[i].smp, directed_rows[i].typed,
                  directed_rows[i].fault, directed_rows[i].temp);
    in_tvalid <= 1'b0;
    drain_results();

    for (int ph = 0; ph < 14; ph++) begin
      if (ph >= 12) begin
        tx_gaps = 0;
        rx_gaps = 0;
      end
      write_reg(tatc_pkg::REG_WINDOW,
                ($urandom_range(0, 7) == 0) ? 64'd64 : 64'($urandom_range(1, 6)));
      write_reg(tatc_pkg::REG_DIVIDER, 64'($urandom_range(1000, 1000000)));
      write_reg(tatc_pkg::REG_COEF_A, tatc_pkg::COEF_A_RST + 64'($urandom_range(0, 1000000)));
      write_reg(tatc_pkg::REG_COEF_B, tatc_pkg::COEF_B_RST + 64'($urandom_range(0, 1000000)));
      write_reg(tatc_pkg::REG_COEF_C, tatc_pkg::COEF_C_RST + 64'($urandom_range(0, 1000)));
      case (ph)
        0: write_reg(tatc_pkg::REG_WINDOW, 64'd0);
        1: write_reg(tatc_pkg::REG_WINDOW, 64'd127);
        2: write_reg(tatc_pkg::REG_DIVIDER, 64'd0);
        3: begin
          write_reg(tatc_pkg::REG_COEF_A, 64'd0);
          write_reg(tatc_pkg::REG_COEF_B, 64'd0);
          write_reg(tatc_pkg::REG_COEF_C, 64'd0);
        end
        4: begin
          write_reg(tatc_pkg::REG_COEF_A, 64'hFFFF_FFFF_FFFF);
          write_reg(tatc_pkg::REG_COEF_B, 64'hFFFF_FFFF_FFFF);
          write_reg(tatc_pkg::REG_COEF_C, 64'hFFFF_FFFF_FFFF);
        end
        5: write_reg(tatc_pkg::REG_DIVIDER, 64'hFF_FFFF);
        6: write_reg(tatc_pkg::REG_WINDOW, 64'd1);
        7: write_reg(tatc_pkg::REG_COEF_A, 64'($urandom_range(0, 100000)));
        default: ;
      endcase
      n = (ph == 1) ? 140 : 69;
      for (int i = 0; i < n; i++) begin
        if (ph == 6 && i == 10) long_hold_req = 1;
        if (ph == 8 && i == 40) begin
          in_tvalid <= 1'b0;
          while (pending_temps.size() != 0) @(posedge clk);
        end
        random_sample();
      end
      in_tvalid <= 1'b0;
      drain_results();
    end

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
